### rtl/core/pool2d_pkg.sv
// Shared constants, register indexes and the controller/datapath interface structs
// for the 2-D pooling core. No dependencies.
`default_nettype none

package pool2d_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int ROW_W       = 10;
   localparam int CFG_W       = 11;
   localparam int IDX_W       = 3;
   localparam int STRIDE_W    = 4;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int DEF_MAX_KERNEL = 8;

   localparam logic [IDX_W-1:0] REG_POOL_MODE     = 3'd0;
   localparam logic [IDX_W-1:0] REG_KERNEL_SIZE   = 3'd1;
   localparam logic [IDX_W-1:0] REG_STRIDE        = 3'd2;
   localparam logic [IDX_W-1:0] REG_PLANE_HEIGHT  = 3'd3;
   localparam logic [IDX_W-1:0] REG_PLANE_WIDTH   = 3'd4;
   localparam logic [IDX_W-1:0] REG_POOLED_HEIGHT = 3'd5;
   localparam logic [IDX_W-1:0] REG_POOLED_WIDTH  = 3'd6;

   localparam logic [3:0]       RST_KERNEL        = 4'd2;
   localparam logic [3:0]       RST_STRIDE        = 4'd2;
   localparam logic [CFG_W-1:0] RST_PLANE_SIZE    = 11'd1024;
   localparam logic [CFG_W-1:0] RST_POOLED_SIZE   = 11'd512;

   typedef struct packed {
      logic load;
      logic mem_rd;
      logic mem_wr;
      logic step;
      logic advance;
      logic div_start;
      logic div_step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic win_valid;
      logic last_win;
      logic hit;
      logic avg;
      logic div_done;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

### rtl/core/pooling_2d_forward_core.sv
// Each accepted pixel walks its windows: every covering window (0 to 64) gets an
// accumulator read and write; a visited window that is skipped (outside the pooled
// grid or missing the pixel) gets neither. When the pixel closes a window, the
// result is emitted, after the divider in average mode. The input stalls until the
// pixel is done. Reset (synchronous, active high) restores register defaults and
// restarts the plane; the accumulator memory is not cleared.
`default_nettype none

module pooling_2d_forward_core import pool2d_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int MAX_KERNEL = DEF_MAX_KERNEL
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // Pixel input channel: one transfer per accepted pixel.
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [SAMPLE_BITS-1:0] req_pixel_value,
   // Pooled result channel.
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]      rsp_pooled_value,
   output logic [ROW_W-1:0]                   rsp_out_row,
   output logic [ROW_W-1:0]                   rsp_out_col,
   output logic                               rsp_plane_done,
   // Register write channel; every write to a listed register restarts the plane.
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [IDX_W-1:0]              csr_index,
   input  wire logic [CFG_W-1:0]              csr_data
);

   cmd_type cmd;
   sts_type sts;

   // The controller sequences the window walk for each pixel: every valid window that
   // covers the pixel gets a read cycle and a write cycle on the accumulator memory.
   pool2d_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .csr_ready (csr_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds settings, counters, the accumulator memory, the divider
   // and the output register, which decouples result transfers from new pixels.
   pool2d_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_KERNEL (MAX_KERNEL)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_pixel_value  (req_pixel_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_pooled_value (rsp_pooled_value),
      .rsp_out_row      (rsp_out_row),
      .rsp_out_col      (rsp_out_col),
      .rsp_plane_done   (rsp_plane_done)
   );

`ifndef NO_ASSERTIONS
   // One pixel at a time: after a transfer the input stalls while it is worked.
   a_one_pixel: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("pixel accepted while previous pixel in work");

   // A result never overwrites one that has not yet transferred.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid || !rsp_stall))
      else $error("result register overwritten");

   // Memory reads only for windows inside the pooled grid.
   a_valid_read: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_rd |-> sts.win_valid)
      else $error("accumulator read for invalid window");
`endif

endmodule

`default_nettype wire

### rtl/core/pool2d_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module pool2d_ram #(
   parameter int WIDTH = 22,
   parameter int DEPTH = 8192
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/core/pool2d_ctrl.sv
// Sequencing state machine of the pooling core: walks the windows of one pixel,
// runs the divider and hands the result to the output register. Uses pool2d_pkg.
`default_nettype none

module pool2d_ctrl import pool2d_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   output logic         csr_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RD   = 3'd1;
   localparam logic [2:0] ST_WR   = 3'd2;
   localparam logic [2:0] ST_FIN  = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_EMIT = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            if (sts.win_valid) begin
               cmd.mem_rd = 1'b1;
               state_in   = ST_WR;
            end else if (sts.last_win) begin
               state_in = ST_FIN;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_WR: begin
            cmd.mem_wr = 1'b1;
            if (sts.last_win) begin
               state_in = ST_FIN;
            end else begin
               cmd.step = 1'b1;
               state_in = ST_RD;
            end
         end
         ST_FIN: begin
            cmd.advance = 1'b1;
            if (sts.hit && sts.avg) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else if (sts.hit) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (sts.div_done) begin
               state_in = ST_EMIT;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);

endmodule

`default_nettype wire

### rtl/core/pool2d_datapath.sv
// Datapath of the pooling core: configuration registers, pixel position counters,
// window walk, accumulator memory, restoring divider and output register.
// Uses pool2d_pkg and pool2d_ram.
`default_nettype none

module pool2d_datapath import pool2d_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int MAX_KERNEL = DEF_MAX_KERNEL
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire cmd_type                       cmd,
   output sts_type                            sts,
   input  wire logic signed [SAMPLE_BITS-1:0] req_pixel_value,
   input  wire logic                          csr_valid,
   input  wire logic                          csr_ready,
   input  wire logic [IDX_W-1:0]              csr_index,
   input  wire logic [CFG_W-1:0]              csr_data,
   input  wire logic                          rsp_stall,
   output logic                               rsp_valid,
   output logic signed [SAMPLE_BITS-1:0]      rsp_pooled_value,
   output logic [ROW_W-1:0]                   rsp_out_row,
   output logic [ROW_W-1:0]                   rsp_out_col,
   output logic                               rsp_plane_done
);

   localparam int MAXDIM  = (MAX_HEIGHT > MAX_WIDTH) ? MAX_HEIGHT : MAX_WIDTH;
   localparam int CRD_RAW = $clog2(MAXDIM + 32);
   localparam int CRD_W   = (CRD_RAW > ROW_W) ? CRD_RAW : ROW_W;
   localparam int KW      = $clog2(MAX_KERNEL + 1);
   localparam int MKW     = $clog2(MAX_KERNEL);
   localparam int CNT_W   = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
   localparam int ACC_W   = SAMPLE_BITS + 2 * $clog2(MAX_KERNEL);
   localparam int DEPTH   = MAX_KERNEL * MAX_WIDTH;
   localparam int AW      = $clog2(DEPTH);
   localparam int DCW     = $clog2(ACC_W + 1);
   localparam int NUM_REGS_LOCAL = 7;

   // Configuration registers.
   logic             mode_ff;
   logic [3:0]       kreg_ff;
   logic [3:0]       sreg_ff;
   logic [CFG_W-1:0] hreg_ff, wreg_ff, phreg_ff, pwreg_ff;
   logic             cfg_we, cfg_hit;

   // Effective (clamped) settings.
   logic [KW-1:0]       k_eff;
   logic [STRIDE_W-1:0] s_eff;
   logic [CRD_W-1:0]    hgt, wid, swh, sww, kx, sx;

   // Pixel position and its quotient/remainder by the stride.
   logic [CRD_W-1:0]    h_ff, w_ff, qh_ff, qw_ff;
   logic [STRIDE_W-1:0] rh_ff, rw_ff;
   logic [MKW-1:0]      qhm_ff;
   logic signed [SAMPLE_BITS-1:0] pix_ff;

   // Window walk.
   logic [CRD_W-1:0] ph_ff, pw_ff, hs_ff, ws_ff;
   logic [MKW-1:0]   modk_ff;
   logic             more_pw, more_ph, vh, vw;
   logic [CRD_W-1:0] he, we;

   // Completed window.
   logic             hit_ff;
   logic [ACC_W-1:0] res_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [CRD_W-1:0] oph_ff, opw_ff;
   logic             odone_ff;

   // Memory and update.
   logic [AW-1:0]    mem_addr;
   logic [ACC_W-1:0] rd_data, v_ext, acc_new;
   logic             first, complete;
   logic [KW-1:0]    hl, wl;

   // Divider.
   logic [ACC_W-1:0] quo_ff;
   logic [CNT_W-1:0] rem_ff;
   logic             neg_ff;
   logic [DCW-1:0]   dcnt_ff;
   logic [CNT_W:0]   rem_t;

   // Output register.
   logic                   rsp_valid_ff, done_ff;
   logic [SAMPLE_BITS-1:0] val_ff;
   logic [ROW_W-1:0]       row_ff, col_ff;
   logic [ACC_W-1:0]       res_val;

   assign cfg_we  = csr_valid && csr_ready;
   assign cfg_hit = cfg_we && (int'(csr_index) < NUM_REGS_LOCAL);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         kreg_ff  <= RST_KERNEL;
         sreg_ff  <= RST_STRIDE;
         hreg_ff  <= RST_PLANE_SIZE;
         wreg_ff  <= RST_PLANE_SIZE;
         phreg_ff <= RST_POOLED_SIZE;
         pwreg_ff <= RST_POOLED_SIZE;
      end else if (cfg_we) begin
         case (csr_index)
            REG_POOL_MODE:     mode_ff  <= csr_data[0];
            REG_KERNEL_SIZE:   kreg_ff  <= csr_data[3:0];
            REG_STRIDE:        sreg_ff  <= csr_data[3:0];
            REG_PLANE_HEIGHT:  hreg_ff  <= csr_data;
            REG_PLANE_WIDTH:   wreg_ff  <= csr_data;
            REG_POOLED_HEIGHT: phreg_ff <= csr_data;
            REG_POOLED_WIDTH:  pwreg_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (kreg_ff == 4'd0) begin
         k_eff = KW'(1);
      end else if (int'(kreg_ff) > MAX_KERNEL) begin
         k_eff = KW'(MAX_KERNEL);
      end else begin
         k_eff = KW'(kreg_ff);
      end
      s_eff = (sreg_ff == 4'd0) ? STRIDE_W'(1) : sreg_ff;

      if (hreg_ff == '0)                    hgt = CRD_W'(1);
      else if (int'(hreg_ff) > MAX_HEIGHT)  hgt = CRD_W'(MAX_HEIGHT);
      else                                  hgt = CRD_W'(hreg_ff);
      if (wreg_ff == '0)                    wid = CRD_W'(1);
      else if (int'(wreg_ff) > MAX_WIDTH)   wid = CRD_W'(MAX_WIDTH);
      else                                  wid = CRD_W'(wreg_ff);
      if (phreg_ff == '0)                   swh = CRD_W'(1);
      else if (int'(phreg_ff) > MAX_HEIGHT) swh = CRD_W'(MAX_HEIGHT);
      else                                  swh = CRD_W'(phreg_ff);
      if (pwreg_ff == '0)                   sww = CRD_W'(1);
      else if (int'(pwreg_ff) > MAX_WIDTH)  sww = CRD_W'(MAX_WIDTH);
      else                                  sww = CRD_W'(pwreg_ff);
   end

   assign kx = CRD_W'(k_eff);
   assign sx = CRD_W'(s_eff);

   // Window walk status. A window index is in range when it is below the
   // software count, covers the pixel and its start still leaves a natural
   // window in the plane. With a stride above the kernel the first window
   // tried may miss the pixel.
   assign vh = (ph_ff < swh) && (h_ff < hs_ff + kx) &&
               ((ph_ff == '0) || (hs_ff + kx < hgt + sx));
   assign vw = (pw_ff < sww) && (w_ff < ws_ff + kx) &&
               ((pw_ff == '0) || (ws_ff + kx < wid + sx));
   assign more_pw = (pw_ff != '0) && (ws_ff + kx > w_ff + sx);
   assign more_ph = (ph_ff != '0) && (hs_ff + kx > h_ff + sx);

   assign he = (hs_ff + kx < hgt) ? hs_ff + kx : hgt;
   assign we = (ws_ff + kx < wid) ? ws_ff + kx : wid;
   assign hl = KW'(he - hs_ff);
   assign wl = KW'(we - ws_ff);

   assign first    = (h_ff == hs_ff) && (w_ff == ws_ff);
   assign complete = (h_ff + CRD_W'(1) == he) && (w_ff + CRD_W'(1) == we);

   assign v_ext = {{(ACC_W - SAMPLE_BITS){pix_ff[SAMPLE_BITS-1]}}, pix_ff};

   always_comb begin
      if (first) begin
         acc_new = v_ext;
      end else if (mode_ff) begin
         acc_new = rd_data + v_ext;
      end else if ($signed(v_ext) > $signed(rd_data)) begin
         acc_new = v_ext;
      end else begin
         acc_new = rd_data;
      end
   end

   assign mem_addr = AW'(modk_ff) * AW'(MAX_WIDTH) + AW'(pw_ff);

   pool2d_ram #(
      .WIDTH (ACC_W),
      .DEPTH (DEPTH)
   ) u_accum_ram (
      .clock   (clock),
      .wr_en   (cmd.mem_wr),
      .wr_addr (mem_addr),
      .wr_data (acc_new),
      .rd_en   (cmd.mem_rd),
      .rd_addr (mem_addr),
      .rd_data (rd_data)
   );

   // Pixel position counters; any write to a listed register restarts the plane.
   always_ff @(posedge clock) begin
      if (reset || cfg_hit) begin
         h_ff   <= '0;
         w_ff   <= '0;
         qh_ff  <= '0;
         qw_ff  <= '0;
         rh_ff  <= '0;
         rw_ff  <= '0;
         qhm_ff <= '0;
      end else if (cmd.advance) begin
         if (w_ff + CRD_W'(1) >= wid) begin
            w_ff  <= '0;
            qw_ff <= '0;
            rw_ff <= '0;
            if (h_ff + CRD_W'(1) >= hgt) begin
               h_ff   <= '0;
               qh_ff  <= '0;
               rh_ff  <= '0;
               qhm_ff <= '0;
            end else begin
               h_ff <= h_ff + CRD_W'(1);
               if (rh_ff + STRIDE_W'(1) == s_eff) begin
                  rh_ff  <= '0;
                  qh_ff  <= qh_ff + CRD_W'(1);
                  qhm_ff <= (qhm_ff == MKW'(MAX_KERNEL - 1)) ? '0 : qhm_ff + MKW'(1);
               end else begin
                  rh_ff <= rh_ff + STRIDE_W'(1);
               end
            end
         end else begin
            w_ff <= w_ff + CRD_W'(1);
            if (rw_ff + STRIDE_W'(1) == s_eff) begin
               rw_ff <= '0;
               qw_ff <= qw_ff + CRD_W'(1);
            end else begin
               rw_ff <= rw_ff + STRIDE_W'(1);
            end
         end
      end
   end

   // Window walk: highest window first, down while the window still covers
   // the pixel; columns inside rows.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pix_ff  <= req_pixel_value;
         ph_ff   <= qh_ff;
         hs_ff   <= h_ff - CRD_W'(rh_ff);
         pw_ff   <= qw_ff;
         ws_ff   <= w_ff - CRD_W'(rw_ff);
         modk_ff <= qhm_ff;
      end else if (cmd.step) begin
         if (more_pw) begin
            pw_ff <= pw_ff - CRD_W'(1);
            ws_ff <= ws_ff - sx;
         end else begin
            ph_ff   <= ph_ff - CRD_W'(1);
            hs_ff   <= hs_ff - sx;
            modk_ff <= (modk_ff == '0) ? MKW'(MAX_KERNEL - 1) : modk_ff - MKW'(1);
            pw_ff   <= qw_ff;
            ws_ff   <= w_ff - CRD_W'(rw_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.load) begin
         hit_ff <= 1'b0;
      end else if (cmd.mem_wr && complete) begin
         hit_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_wr && complete) begin
         res_ff   <= acc_new;
         cnt_ff   <= CNT_W'(hl) * CNT_W'(wl);
         oph_ff   <= ph_ff;
         opw_ff   <= pw_ff;
         odone_ff <= ((ph_ff + CRD_W'(1) >= swh) || (hs_ff + kx >= hgt)) &&
                     ((pw_ff + CRD_W'(1) >= sww) || (ws_ff + kx >= wid));
      end
   end

   // Restoring divider on the magnitude, one quotient bit per cycle.
   assign rem_t = {rem_ff, quo_ff[ACC_W-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= '0;
      end else if (cmd.div_start) begin
         dcnt_ff <= DCW'(ACC_W);
      end else if (cmd.div_step) begin
         dcnt_ff <= dcnt_ff - DCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         neg_ff <= res_ff[ACC_W-1];
         quo_ff <= res_ff[ACC_W-1] ? (~res_ff + ACC_W'(1)) : res_ff;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         if (rem_t >= {1'b0, cnt_ff}) begin
            rem_ff <= CNT_W'(rem_t - {1'b0, cnt_ff});
            quo_ff <= {quo_ff[ACC_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_t[CNT_W-1:0];
            quo_ff <= {quo_ff[ACC_W-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      if (!mode_ff) begin
         res_val = res_ff;
      end else if (neg_ff) begin
         res_val = ~quo_ff + ACC_W'(1);
      end else begin
         res_val = quo_ff;
      end
   end

   // Output register: a new result can load while the previous one transfers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         val_ff  <= res_val[SAMPLE_BITS-1:0];
         row_ff  <= oph_ff[ROW_W-1:0];
         col_ff  <= opw_ff[ROW_W-1:0];
         done_ff <= odone_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pooled_value = $signed(val_ff);
   assign rsp_out_row      = row_ff;
   assign rsp_out_col      = col_ff;
   assign rsp_plane_done   = done_ff;

   assign sts.win_valid = vh && vw;
   assign sts.last_win  = !more_pw && !more_ph;
   assign sts.hit       = hit_ff;
   assign sts.avg       = mode_ff;
   assign sts.div_done  = (dcnt_ff == '0);
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for pooling_2d_forward_core: max and average pooling over
// raster-order Q8.8 planes, checked against an in-bench predictor. Depends on pool2d_pkg.
`timescale 1ns / 1ps

module testbench;
   import pool2d_pkg::*;

   // Index beyond the register list; a write to it must be ignored entirely.
   localparam logic [IDX_W-1:0] REG_UNLISTED = 3'd7;
   localparam int NUM_REGS   = 7;
   localparam int ACC_ROWS   = DEF_MAX_KERNEL;
   localparam int CYCLE_CAP  = 4000000;
   localparam int DRAIN_WAIT = 250;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] value;
      logic [ROW_W-1:0]              row;
      logic [ROW_W-1:0]              col;
      logic                          done;
   } pooled_type;

   // The scoreboard owns a copy of the register file, the window accumulators and the
   // raster position. Each accepted pixel is folded into every window of the pooled grid
   // that covers it; a pixel that closes a window queues the pooled value it must produce.
   class pool_scoreboard_type;
      logic [CFG_W-1:0] regs[NUM_REGS];
      longint           window_acc[ACC_ROWS * DEF_MAX_WIDTH];
      int               row_pos, col_pos;
      pooled_type       pending[$];
      int               failures, pixels, matched, averaged;

      function new();
         regs = '{0, RST_KERNEL, RST_STRIDE, RST_PLANE_SIZE, RST_PLANE_SIZE,
                  RST_POOLED_SIZE, RST_POOLED_SIZE};
         row_pos = 0;
         col_pos = 0;
      endfunction

      task report(string msg);
         failures++;
         $display("MISMATCH at %0t: %s", $realtime, msg);
      endtask

      function void write_reg(int idx, logic [CFG_W-1:0] data);
         if (idx >= NUM_REGS) return;
         case (idx)
            REG_POOL_MODE: regs[idx] = data & 11'h1;
            REG_KERNEL_SIZE, REG_STRIDE: regs[idx] = data & 11'hF;
            default: regs[idx] = data;
         endcase
         row_pos = 0;
         col_pos = 0;
      endfunction

      function int clip(int v, int lo, int hi);
         return (v < lo) ? lo : (v > hi) ? hi : v;
      endfunction

      // Windows along one axis: the natural count, capped by the software setting.
      function int axis_windows(int size, int k, int s, int sw);
         int nat;
         nat = 1;
         if (size > k) nat = (size - k + s - 1) / s + 1;
         if (sw < 1) sw = 1;
         return (sw < nat) ? sw : nat;
      endfunction

      function void note_input(logic signed [SAMPLE_BITS-1:0] pix);
         bit     avg, emitted;
         int     k, s, hgt, wid, nph, npw, h, w;
         int     ph_lo, ph_hi, pw_lo, pw_hi, hs, he, ws, we, idx;
         longint v, r;
         pooled_type res;
         avg = regs[REG_POOL_MODE][0];
         k   = clip(int'(regs[REG_KERNEL_SIZE]), 1, DEF_MAX_KERNEL);
         s   = clip(int'(regs[REG_STRIDE]), 1, 15);
         hgt = clip(int'(regs[REG_PLANE_HEIGHT]), 1, DEF_MAX_HEIGHT);
         wid = clip(int'(regs[REG_PLANE_WIDTH]), 1, DEF_MAX_WIDTH);
         nph = axis_windows(hgt, k, s, int'(regs[REG_POOLED_HEIGHT]));
         npw = axis_windows(wid, k, s, int'(regs[REG_POOLED_WIDTH]));
         h = (row_pos >= hgt) ? 0 : row_pos;
         w = (col_pos >= wid) ? 0 : col_pos;
         v = pix;
         emitted = 0;
         pixels++;
         ph_lo = (h + 1 > k) ? (h + 1 - k + s - 1) / s : 0;
         ph_hi = h / s;
         if (ph_hi > nph - 1) ph_hi = nph - 1;
         pw_lo = (w + 1 > k) ? (w + 1 - k + s - 1) / s : 0;
         pw_hi = w / s;
         if (pw_hi > npw - 1) pw_hi = npw - 1;
         for (int ph = ph_lo; ph <= ph_hi; ph++) begin
            hs = ph * s;
            he = (hs + k < hgt) ? hs + k : hgt;
            for (int pw = pw_lo; pw <= pw_hi; pw++) begin
               ws  = pw * s;
               we  = (ws + k < wid) ? ws + k : wid;
               idx = (ph % ACC_ROWS) * DEF_MAX_WIDTH + pw;
               if (h == hs && w == ws) window_acc[idx] = v;
               else if (avg) window_acc[idx] += v;
               else if (v > window_acc[idx]) window_acc[idx] = v;
               if (h == he - 1 && w == we - 1 && !emitted) begin
                  r = window_acc[idx];
                  // Division truncates toward zero, as the hardware divider must.
                  if (avg) r = r / longint'((he - hs) * (we - ws));
                  res.value = r[SAMPLE_BITS-1:0];
                  res.row   = ph[ROW_W-1:0];
                  res.col   = pw[ROW_W-1:0];
                  res.done  = (ph == nph - 1 && pw == npw - 1);
                  pending.push_back(res);
                  if (avg) averaged++;
                  emitted = 1;
               end
            end
         end
         w++;
         if (w >= wid) begin
            w = 0;
            h++;
            if (h >= hgt) h = 0;
         end
         row_pos = h;
         col_pos = w;
      endfunction

      task check_result(pooled_type got);
         pooled_type want;
         if (pending.size() == 0) begin
            report($sformatf("unexpected result value=%0d row=%0d col=%0d",
                             got.value, got.row, got.col));
            return;
         end
         want = pending.pop_front();
         matched++;
         if (got.value !== want.value)
            report($sformatf("pooled_value %0d, expected %0d (row %0d col %0d)",
                             got.value, want.value, want.row, want.col));
         if (got.row !== want.row)
            report($sformatf("out_row %0d, expected %0d", got.row, want.row));
         if (got.col !== want.col)
            report($sformatf("out_col %0d, expected %0d", got.col, want.col));
         if (got.done !== want.done)
            report($sformatf("plane_done %0b, expected %0b (row %0d col %0d)",
                             got.done, want.done, want.row, want.col));
      endtask
   endclass

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic signed [SAMPLE_BITS-1:0] req_pixel_value;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic signed [SAMPLE_BITS-1:0] rsp_pooled_value;
   logic [ROW_W-1:0]              rsp_out_row;
   logic [ROW_W-1:0]              rsp_out_col;
   logic                          rsp_plane_done;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [IDX_W-1:0]              csr_index;
   logic [CFG_W-1:0]              csr_data;

   pool_scoreboard_type pool_sb;
   int                  cycle_count;
   int                  phase_count;
   bit                  gaps_enabled;

   pooling_2d_forward_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel_value (req_pixel_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pooled_value(rsp_pooled_value),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_plane_done  (rsp_plane_done),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // The watchdog counts every cycle and ends a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_CAP) begin
         $display("Timeout after %0d cycles, %0d results still expected",
                  cycle_count, pool_sb.pending.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // Result side. A transfer is sampled at the edge where valid is high and stall is
   // low, using the values that were settled before the edge. The stall pattern walks
   // through four regimes: never, light random, heavy random and long periodic stalls.
   always @(posedge clock) begin
      pooled_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.value = rsp_pooled_value;
         got.row   = rsp_out_row;
         got.col   = rsp_out_col;
         got.done  = rsp_plane_done;
         pool_sb.check_result(got);
      end
      case ((cycle_count / 900) % 4)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= ((cycle_count % 41) < 17);
      endcase
   end

   // Sends one pixel and returns once the transfer has happened. Valid may stay high
   // into the next call, so the next pixel is offered as soon as the core stops stalling.
   task send_pixel(logic signed [SAMPLE_BITS-1:0] pix);
      req_valid       <= 1'b1;
      req_pixel_value <= pix;
      do @(posedge clock); while (req_stall);
      pool_sb.note_input(pix);
   endtask

   // Random pixel, biased toward full-scale and near-zero values.
   function logic signed [SAMPLE_BITS-1:0] pick_pixel();
      case ($urandom_range(0, 7))
         0: return 16'sh7FFF;
         1: return -16'sh8000;
         2: return 16'($signed($urandom_range(0, 6)) - 3);
         default: return 16'($urandom);
      endcase
   endfunction

   // Bursts of random length separated by random gaps, unless gaps are disabled.
   task send_random(int count);
      int burst;
      burst = $urandom_range(1, 40);
      for (int i = 0; i < count; i++) begin
         send_pixel(pick_pixel());
         burst--;
         if (burst == 0 && gaps_enabled) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            burst = $urandom_range(1, 40);
         end
      end
      req_valid <= 1'b0;
   endtask

   // Waits until every expected result has come back, then lets pixels that close no
   // window finish their accumulator passes before anything else happens.
   task drain();
      req_valid <= 1'b0;
      while (pool_sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task write_csr(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      pool_sb.write_reg(int'(idx), data);
   endtask

   task setup_plane(int mode, int k, int s, int hgt, int wid, int phgt, int pwid);
      drain();
      write_csr(REG_POOL_MODE, CFG_W'(mode));
      write_csr(REG_KERNEL_SIZE, CFG_W'(k));
      write_csr(REG_STRIDE, CFG_W'(s));
      write_csr(REG_PLANE_HEIGHT, CFG_W'(hgt));
      write_csr(REG_PLANE_WIDTH, CFG_W'(wid));
      write_csr(REG_POOLED_HEIGHT, CFG_W'(phgt));
      write_csr(REG_POOLED_WIDTH, CFG_W'(pwid));
      phase_count++;
   endtask

   // Pooled size for one axis: usually the natural count, sometimes zero, an oversize
   // value, or a random count up to the natural one, which may trim the last windows.
   function int pick_pooled(int size, int k, int s);
      int kk, ss, nat;
      kk  = (k < 1) ? 1 : (k > DEF_MAX_KERNEL) ? DEF_MAX_KERNEL : k;
      ss  = (s < 1) ? 1 : s;
      if (size < 1) size = 1;
      if (size > DEF_MAX_WIDTH) size = DEF_MAX_WIDTH;
      nat = (size > kk) ? (size - kk + ss - 1) / ss + 1 : 1;
      case ($urandom_range(0, 7))
         0: return 0;
         1: return 2047;
         2: return $urandom_range(1, nat);
         default: return nat;
      endcase
   endfunction

   initial begin
      int mode, k, s, hgt, wid, plane, count, total;
      logic signed [SAMPLE_BITS-1:0] corner_pix[16];
      pool_sb         = new();
      cycle_count     = 0;
      phase_count     = 0;
      gaps_enabled    = 1'b1;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_pixel_value = '0;
      rsp_stall       = 1'b0;
      csr_valid       = 1'b0;
      csr_index       = '0;
      csr_data        = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. A 4x4 plane in max mode with 2x2 windows sees the full-scale
      // extremes, zero and the values next to it, including a window that is all
      // negative so a stale zero maximum would show.
      corner_pix = '{16'sh7FFF, -16'sh8000, 16'sh0001, 16'sh0000,
                     -16'sh0001, -16'sh8000, 16'sh0100, -16'sh7FFF,
                     -16'sh8000, -16'sh8000, 16'sh7FFE, 16'sh7FFF,
                     -16'sh0002, -16'sh8000, -16'sh0003, -16'sh0100};
      setup_plane(0, 2, 2, 4, 4, 2, 2);
      foreach (corner_pix[i]) send_pixel(corner_pix[i]);
      // Average mode, a single 3x3 window over the whole 3x3 plane; its sum is negative,
      // so the signed division is checked.
      setup_plane(1, 3, 1, 3, 3, 1, 1);
      for (int i = 0; i < 9; i++) send_pixel(corner_pix[15 - i]);

      // A write to an index outside the register list must change nothing: the
      // plane in progress carries on where it was.
      setup_plane(1, 2, 2, 2, 4, 1, 2);
      send_pixel(-16'sh8000);
      send_pixel(-16'sh7FFF);
      drain();
      write_csr(REG_UNLISTED, 11'h7FF);
      send_pixel(-16'sh0001);
      send_pixel(16'sh0003);
      send_random(4);

      // Extreme register values: zero and oversize kernel and stride, a kernel larger
      // than the plane, the largest height, and the largest width with 1x1 windows.
      setup_plane(0, 0, 0, 0, 0, 0, 0);
      send_random(5);
      setup_plane(1, 15, 15, 5, 6, 2047, 2047);
      send_random(60);
      setup_plane(0, 3, 15, 7, 20, 2047, 2047);
      send_random(140);
      setup_plane(1, 2, 1, 2047, 3, 2047, 2047);
      send_random(90);
      setup_plane(0, 1, 1, 2, 2047, 2047, 2047);
      send_random(160);
      setup_plane(1, 8, 8, 8, 8, 1, 1);
      send_random(64);

      // Random part: random geometry and mode per phase, several planes or a partial
      // plane each, so counters wrap and the next configuration restarts mid-plane.
      total = pool_sb.pixels;
      while (pool_sb.pixels < 1850) begin
         mode = $urandom_range(0, 1);
         k    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
         s    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
         hgt  = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 14);
         wid  = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 24);
         setup_plane(mode, k, s, hgt, wid, pick_pooled(hgt, k, s), pick_pooled(wid, k, s));
         plane = ((hgt < 1) ? 1 : hgt) * ((wid < 1) ? 1 : wid);
         count = ($urandom_range(0, 3) == 0) ? $urandom_range(1, plane)
                                             : plane * $urandom_range(1, 3);
         if (count > 300) count = 300;
         gaps_enabled = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 4) == 0) begin
            // Hold off mid-phase until everything expected so far has arrived.
            send_random(count / 2);
            while (pool_sb.pending.size() != 0) @(posedge clock);
            send_random(count - count / 2);
         end else begin
            send_random(count);
         end
      end
      gaps_enabled = 1'b1;

      drain();
      $display("Covered %0d pixels over %0d register settings; %0d pooled results checked,",
               pool_sb.pixels, phase_count, pool_sb.matched);
      $display("%0d of them averages, the rest maxima.", pool_sb.averaged);
      if (pool_sb.failures == 0 && pool_sb.pending.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches, %0d results never arrived", pool_sb.failures,
                  pool_sb.pending.size());
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
